// File: rtl/core/dbeq_pkg.sv
`timescale 1ns / 1ps

package dbeq_pkg;

   // default ring size of one bank
   localparam int RING_DEPTH_DEF = 64;

   // request modes
   localparam logic [2:0] MODE_PUSH    = 3'd0;
   localparam logic [2:0] MODE_SWAP    = 3'd1;
   localparam logic [2:0] MODE_CLEAR   = 3'd2;
   localparam logic [2:0] MODE_READ    = 3'd3;
   localparam logic [2:0] MODE_COLLECT = 3'd4;

   // response status codes
   localparam logic [2:0] STAT_PUSHED    = 3'd0;
   localparam logic [2:0] STAT_DROPPED   = 3'd1;
   localparam logic [2:0] STAT_SWAPPED   = 3'd2;
   localparam logic [2:0] STAT_CLEARED   = 3'd3;
   localparam logic [2:0] STAT_READ      = 3'd4;
   localparam logic [2:0] STAT_RANGE     = 3'd5;
   localparam logic [2:0] STAT_COLLECTED = 3'd6;
   localparam logic [2:0] STAT_EMPTY     = 3'd7;

   // one stored event, as kept in the ring memory
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] amount;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_END
   } state_type;

endpackage

// File: rtl/core/dbeq_ram.sv
`timescale 1ns / 1ps

module dbeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/double_buffered_event_queue.sv
`timescale 1ns / 1ps

// Two-bank event queue with drop-oldest overflow.
// Request channel (req_*): one operation per transfer, chosen by req_mode:
// push, swap, clear, read at index, collect by kind. Undefined modes are
// taken and ignored; they give no response.
// Response channel (rsp_*): one transfer per operation, one or more for a
// collect; rsp_last marks the final one. Event fields read zero when the
// response carries no event.
// Push, swap, clear and an out-of-range read load the response register
// on the request transfer; an in-range read loads it after the memory read.
// A collect walks the front bank entry by entry (memory read, then match)
// until the bank ends or req_collect_cap matches are found; one matching
// event is held back so that the last one can carry rsp_last.
// Throughput: with rsp_ready high, one push, swap or clear per cycle.
// Requests are taken only in idle, with the response register free or emptying.
// A stalled receiver holds the response register and stalls the scan once a held match must be released.
// Reset (synchronous): both banks empty, counters zero; memory contents are
// not cleared, since only entries written since the last swap or clear are
// ever read.

module double_buffered_event_queue #(
   parameter int RING_DEPTH = dbeq_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_event_kind,
   input  logic [31:0] req_event_src,
   input  logic [31:0] req_event_dst,
   input  logic [31:0] req_event_amount,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [7:0]  req_read_index,
   input  logic [6:0]  req_collect_cap,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_out_kind,
   output logic [31:0] rsp_out_src,
   output logic [31:0] rsp_out_dst,
   output logic [31:0] rsp_out_amount,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_front_count,
   output logic        rsp_last,
   output logic [31:0] rsp_total_seen,
   output logic [31:0] rsp_total_dropped
);

   localparam int HW = $clog2(RING_DEPTH);       // head / position width
   localparam int LW = $clog2(RING_DEPTH + 1);   // length width
   localparam int MEM_DEPTH = 2 * RING_DEPTH;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int EW = $bits(dbeq_pkg::event_type);

   // control state
   dbeq_pkg::state_type state_ff, state_in;
   logic          bank_ff, bank_in;               // back bank number
   logic [LW-1:0] back_len_ff, back_len_in;
   logic [HW-1:0] back_head_ff, back_head_in;
   logic [LW-1:0] front_len_ff, front_len_in;
   logic [HW-1:0] front_head_ff, front_head_in;
   logic [31:0]   seen_ff, seen_in;
   logic [31:0]   dropped_ff, dropped_in;
   logic [LW-1:0] scan_ff, scan_in;               // next front position to read
   logic [6:0]    hits_ff, hits_in;               // matches so far, pending included
   logic [3:0]    filter_ff, filter_in;
   logic [6:0]    cap_ff, cap_in;
   logic          pend_valid_ff, pend_valid_in;
   dbeq_pkg::event_type pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // response payload register
   dbeq_pkg::event_type rsp_event_ff;
   logic [2:0]    rsp_status_ff;
   logic [6:0]    rsp_front_count_ff;
   logic          rsp_last_ff;
   logic [31:0]   rsp_seen_ff;
   logic [31:0]   rsp_dropped_ff;

   // response load
   logic                out_free;
   logic                out_load;
   dbeq_pkg::event_type out_event;
   logic [2:0]          out_status;
   logic                out_last;

   // memory ports
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   dbeq_pkg::event_type wr_event;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       rd_data;
   dbeq_pkg::event_type rd_event;

   // address arithmetic
   logic [HW:0]   push_sum;
   logic [HW-1:0] push_pos;
   logic [HW-1:0] front_off;
   logic [HW:0]   front_sum;
   logic [HW-1:0] front_pos;
   logic [AW-1:0] front_addr;
   logic          req_xfer;
   logic          back_full;
   logic          hit;

   assign rd_event = dbeq_pkg::event_type'(rd_data);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dbeq_pkg::ST_IDLE) && out_free;
   assign req_xfer = req_valid && req_ready;
   assign back_full = (back_len_ff == LW'(RING_DEPTH));

   // slot of a push into the back ring (tail when not full, head when full)
   always_comb begin
      push_sum = {1'b0, back_head_ff} + (HW + 1)'(back_len_ff);
      if (back_full) begin
         push_pos = back_head_ff;
      end else if (push_sum >= (HW + 1)'(RING_DEPTH)) begin
         push_pos = HW'(push_sum - (HW + 1)'(RING_DEPTH));
      end else begin
         push_pos = push_sum[HW-1:0];
      end
   end

   // slot of a front position: read index in idle, scan counter otherwise
   always_comb begin
      if (state_ff == dbeq_pkg::ST_IDLE) begin
         front_off = req_read_index[HW-1:0];
      end else begin
         front_off = scan_ff[HW-1:0];
      end
      front_sum = {1'b0, front_head_ff} + {1'b0, front_off};
      if (front_sum >= (HW + 1)'(RING_DEPTH)) begin
         front_pos = HW'(front_sum - (HW + 1)'(RING_DEPTH));
      end else begin
         front_pos = front_sum[HW-1:0];
      end
      if (bank_ff) begin
         front_addr = AW'(front_pos);            // front is bank 0
      end else begin
         front_addr = AW'(RING_DEPTH) + AW'(front_pos);
      end
   end

   assign hit = (filter_ff == 4'd0) || (rd_event.kind == filter_ff);

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      back_len_in   = back_len_ff;
      back_head_in  = back_head_ff;
      front_len_in  = front_len_ff;
      front_head_in = front_head_ff;
      seen_in       = seen_ff;
      dropped_in    = dropped_ff;
      scan_in       = scan_ff;
      hits_in       = hits_ff;
      filter_in     = filter_ff;
      cap_in        = cap_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;

      out_load   = 1'b0;
      out_event  = '0;
      out_status = dbeq_pkg::STAT_PUSHED;
      out_last   = 1'b1;

      wr_en    = 1'b0;
      wr_addr  = bank_ff ? AW'(RING_DEPTH) + AW'(push_pos) : AW'(push_pos);
      wr_event.kind   = req_event_kind;
      wr_event.src    = req_event_src;
      wr_event.dst    = req_event_dst;
      wr_event.amount = req_event_amount;
      wr_event.x      = req_pos_x;
      wr_event.y      = req_pos_y;
      wr_event.z      = req_pos_z;
      rd_en    = 1'b0;
      rd_addr  = front_addr;

      case (state_ff)
         dbeq_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (req_mode)
                  dbeq_pkg::MODE_PUSH: begin
                     wr_en    = 1'b1;
                     seen_in  = seen_ff + 32'd1;
                     out_load = 1'b1;
                     if (back_full) begin
                        if (back_head_ff == HW'(RING_DEPTH - 1)) begin
                           back_head_in = '0;
                        end else begin
                           back_head_in = back_head_ff + HW'(1);
                        end
                        dropped_in = dropped_ff + 32'd1;
                        out_status = dbeq_pkg::STAT_DROPPED;
                     end else begin
                        back_len_in = back_len_ff + LW'(1);
                        out_status  = dbeq_pkg::STAT_PUSHED;
                     end
                  end
                  dbeq_pkg::MODE_SWAP: begin
                     bank_in       = !bank_ff;
                     front_head_in = back_head_ff;
                     front_len_in  = back_len_ff;
                     back_head_in  = '0;
                     back_len_in   = '0;
                     out_load      = 1'b1;
                     out_status    = dbeq_pkg::STAT_SWAPPED;
                  end
                  dbeq_pkg::MODE_CLEAR: begin
                     front_head_in = '0;
                     front_len_in  = '0;
                     back_head_in  = '0;
                     back_len_in   = '0;
                     out_load      = 1'b1;
                     out_status    = dbeq_pkg::STAT_CLEARED;
                  end
                  dbeq_pkg::MODE_READ: begin
                     if (req_read_index < 8'(front_len_ff)) begin
                        rd_en    = 1'b1;
                        state_in = dbeq_pkg::ST_READ;
                     end else begin
                        out_load   = 1'b1;
                        out_status = dbeq_pkg::STAT_RANGE;
                     end
                  end
                  dbeq_pkg::MODE_COLLECT: begin
                     filter_in     = req_event_kind;
                     cap_in        = req_collect_cap;
                     scan_in       = '0;
                     hits_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = dbeq_pkg::ST_SCAN_RD;
                  end
                  default: begin
                     // undefined mode: taken, no effect, no response
                  end
               endcase
            end
         end
         dbeq_pkg::ST_READ: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_event  = rd_event;
               out_status = dbeq_pkg::STAT_READ;
               state_in   = dbeq_pkg::ST_IDLE;
            end
         end
         dbeq_pkg::ST_SCAN_RD: begin
            if ((scan_ff < front_len_ff) && (hits_ff < cap_ff)) begin
               rd_en    = 1'b1;
               scan_in  = scan_ff + LW'(1);
               state_in = dbeq_pkg::ST_SCAN_CHK;
            end else begin
               state_in = dbeq_pkg::ST_SCAN_END;
            end
         end
         dbeq_pkg::ST_SCAN_CHK: begin
            if (!hit) begin
               state_in = dbeq_pkg::ST_SCAN_RD;
            end else if (!pend_valid_ff || out_free) begin
               // a newer match releases the held one, not last
               if (pend_valid_ff) begin
                  out_load   = 1'b1;
                  out_event  = pend_ff;
                  out_status = dbeq_pkg::STAT_COLLECTED;
                  out_last   = 1'b0;
               end
               pend_in       = rd_event;
               pend_valid_in = 1'b1;
               hits_in       = hits_ff + 7'd1;
               state_in      = dbeq_pkg::ST_SCAN_RD;
            end
         end
         dbeq_pkg::ST_SCAN_END: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_valid_ff) begin
                  out_event  = pend_ff;
                  out_status = dbeq_pkg::STAT_COLLECTED;
               end else begin
                  out_status = dbeq_pkg::STAT_EMPTY;
               end
               pend_valid_in = 1'b0;
               state_in      = dbeq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dbeq_pkg::ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dbeq_pkg::ST_IDLE;
         bank_ff       <= 1'b0;
         back_len_ff   <= '0;
         back_head_ff  <= '0;
         front_len_ff  <= '0;
         front_head_ff <= '0;
         seen_ff       <= '0;
         dropped_ff    <= '0;
         scan_ff       <= '0;
         hits_ff       <= '0;
         filter_ff     <= '0;
         cap_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         back_len_ff   <= back_len_in;
         back_head_ff  <= back_head_in;
         front_len_ff  <= front_len_in;
         front_head_ff <= front_head_in;
         seen_ff       <= seen_in;
         dropped_ff    <= dropped_in;
         scan_ff       <= scan_in;
         hits_ff       <= hits_in;
         filter_ff     <= filter_in;
         cap_ff        <= cap_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: held match and response register
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (out_load) begin
         rsp_event_ff       <= out_event;
         rsp_status_ff      <= out_status;
         rsp_front_count_ff <= 7'(front_len_in);
         rsp_last_ff        <= out_last;
         rsp_seen_ff        <= seen_in;
         rsp_dropped_ff     <= dropped_in;
      end
   end

   // both banks in one memory: bank b at b * RING_DEPTH
   dbeq_ram #(
      .WIDTH (EW),
      .DEPTH (MEM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_event),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_kind      = rsp_event_ff.kind;
   assign rsp_out_src       = rsp_event_ff.src;
   assign rsp_out_dst       = rsp_event_ff.dst;
   assign rsp_out_amount    = rsp_event_ff.amount;
   assign rsp_out_x         = rsp_event_ff.x;
   assign rsp_out_y         = rsp_event_ff.y;
   assign rsp_out_z         = rsp_event_ff.z;
   assign rsp_status        = rsp_status_ff;
   assign rsp_front_count   = rsp_front_count_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_total_seen    = rsp_seen_ff;
   assign rsp_total_dropped = rsp_dropped_ff;

endmodule
